FILE: hw/rtl/rnp_pkg.sv
// ============================================================================
// rnp_pkg - shared types and constants of the ringtone note parser
// Character codes, header defaults, the controller/datapath command and
// status bundles and the note letter decode.
// ============================================================================
package rnp_pkg;

  // divider and arithmetic widths
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // ms per minute, the dividend of the tempo division
  localparam logic [DIV_W-1:0] MS_PER_MIN = 16'd60000;

  // header defaults
  localparam logic [7:0] DEF_LENGTH = 8'd4;
  localparam logic [2:0] DEF_OCTAVE = 3'd6;
  localparam logic [7:0] DEF_BPM    = 8'd63;

  // register map (register index taken from the address)
  localparam logic REG_OCTAVE_SHIFT = 1'b0;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;      // latch the accepted request
    logic acc_clr;      // clear the digit accumulator
    logic acc_add;      // accumulate one decimal digit
    logic set_dlen;     // default length from the accumulator
    logic set_doct;     // default octave from the byte
    logic set_bpm;      // tempo from the accumulator
    logic whole_zero;   // zero tempo: whole note 0, tempo error
    logic div_start;    // launch the shared divider
    logic div_note;     // 1: note duration, 0: whole note time
    logic dur_zero;     // zero divisor: duration 0, note error
    logic set_semi;     // semitone from the note letter
    logic semi_inc;     // sharp
    logic dur_dot;      // dotted extension
    logic oct_digit;    // note octave from the byte
    logic oct_def;      // note octave from the default
    logic ld_out;       // capture a result into the output register
    logic use_def_oct;  // result takes the default octave
    logic rel_out;      // present the output register
    logic rel_last;     // last-note flag for the presented result
    logic restart;      // back to the start-of-string state
  } rnp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_digit;
    logic is_colon;
    logic is_d;
    logic is_o;
    logic is_b;
    logic is_comma;
    logic is_sharp;
    logic is_dot;
    logic oct_ok;
    logic acc_zero;
    logic div_zero;
    logic bpm_zero;
    logic end_flag;
    logic out_busy;
    logic div_done;
  } rnp_stat_t;

  // note letter to semitone, 0 for a rest or an unknown letter
  function automatic logic [3:0] letter_semitone(input logic [7:0] c);
    logic [3:0] s;
    case (c)
      CH_C:    s = 4'd1;
      CH_D:    s = 4'd3;
      CH_E:    s = 4'd5;
      CH_F:    s = 4'd6;
      CH_G:    s = 4'd8;
      CH_A:    s = 4'd10;
      CH_B:    s = 4'd12;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/rnp_div.sv
// ============================================================================
// rnp_div - shared iterative divider
// Restoring unsigned division, one quotient bit per cycle. Operands are
// latched at start; done pulses as the last step is registered.
// ============================================================================
module rnp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rnp_pkg::DIV_W-1:0]    dividend_i,
  input  logic [rnp_pkg::DIV_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [rnp_pkg::DIV_W-1:0]    quotient_o
);

  localparam int unsigned W  = rnp_pkg::DIV_W;
  localparam int unsigned CW = rnp_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W+1:0]  trial;

  // one restoring step
  always_comb begin
    trial  = {1'b0, rem_q, quo_q[W-1]} - {2'b00, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = trial[W+1] ? {rem_q[W-2:0], quo_q[W-1]} : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ~trial[W+1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/rnp_dpath.sv
// ============================================================================
// rnp_dpath - ringtone parser datapath
// Holds the byte being parsed, the header defaults, the note under
// construction and the output register, and owns the shared divider.
// ============================================================================
module rnp_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rnp_pkg::rnp_cmd_t  cmd_i,
  output rnp_pkg::rnp_stat_t stat_o,
  input  logic [7:0]         char_byte_i,
  input  logic               end_of_string_i,
  input  logic [7:0]         octave_shift_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [5:0]         pitch_index_o,
  output logic               pitch_valid_o,
  output logic               is_rest_o,
  output logic [15:0]        duration_ms_o,
  output logic               div_error_o,
  output logic               last_note_o
);

  // latched request
  logic [7:0]  char_q, char_d;
  logic        end_q, end_d;
  // parse state
  logic [15:0] acc_q, acc_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [2:0]  doct_q, doct_d;
  logic [7:0]  bpm_q, bpm_d;
  logic [15:0] whole_q, whole_d;
  logic [3:0]  semi_q, semi_d;
  logic [15:0] dur_q, dur_d;
  logic [7:0]  oct_q, oct_d;
  logic        bpm_err_q, bpm_err_d;
  logic        note_err_q, note_err_d;
  logic        div_op_q, div_op_d;
  // output register
  logic        ovld_q, ovld_d;
  logic        olast_q, olast_d;
  logic [5:0]  opitch_q;
  logic        opval_q;
  logic        orest_q;
  logic [15:0] odur_q;
  logic        oerr_q;

  logic        is_digit;
  logic [3:0]  digit;
  logic [15:0] note_div;
  logic [15:0] dividend;
  logic [15:0] divisor;
  logic        div_done;
  logic [15:0] quotient;
  logic [7:0]  oct_sel;
  logic signed [12:0] oct_off;
  logic signed [12:0] idx_s;
  logic        in_rng;
  logic        rest;

  // byte classification
  assign is_digit = (char_q >= rnp_pkg::CH_0) && (char_q <= rnp_pkg::CH_9);
  assign digit    = char_q[3:0];
  assign note_div = (acc_q != 16'd0) ? acc_q : {8'd0, dlen_q};

  always_comb begin
    stat_o.is_digit = is_digit;
    stat_o.is_colon = (char_q == rnp_pkg::CH_COLON);
    stat_o.is_d     = (char_q == rnp_pkg::CH_D);
    stat_o.is_o     = (char_q == rnp_pkg::CH_O);
    stat_o.is_b     = (char_q == rnp_pkg::CH_B);
    stat_o.is_comma = (char_q == rnp_pkg::CH_COMMA);
    stat_o.is_sharp = (char_q == rnp_pkg::CH_SHARP);
    stat_o.is_dot   = (char_q == rnp_pkg::CH_DOT);
    stat_o.oct_ok   = (char_q >= rnp_pkg::CH_3) && (char_q <= rnp_pkg::CH_7);
    stat_o.acc_zero = (acc_q == 16'd0);
    stat_o.div_zero = (note_div == 16'd0);
    stat_o.bpm_zero = (bpm_q == 8'd0);
    stat_o.end_flag = end_q;
    stat_o.out_busy = ovld_q;
    stat_o.div_done = div_done;
  end

  // shared divider: tempo division or note duration
  assign dividend = cmd_i.div_note ? whole_q : rnp_pkg::MS_PER_MIN;
  assign divisor  = cmd_i.div_note ? note_div : {8'd0, bpm_q};

  rnp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // pitch index of the note in hand
  always_comb begin
    oct_sel = cmd_i.use_def_oct ? ({5'd0, doct_q} + octave_shift_i) : oct_q;
    oct_off = $signed({5'd0, oct_sel}) - 13'sd4;
    idx_s   = (oct_off <<< 3) + (oct_off <<< 2) + $signed({9'd0, semi_q});
    in_rng  = (idx_s >= 13'sd1) && (idx_s <= 13'sd48);
    rest    = (semi_q == 4'd0);
  end

  // next parse state
  always_comb begin
    char_d     = char_q;
    end_d      = end_q;
    acc_d      = acc_q;
    dlen_d     = dlen_q;
    doct_d     = doct_q;
    bpm_d      = bpm_q;
    whole_d    = whole_q;
    semi_d     = semi_q;
    dur_d      = dur_q;
    oct_d      = oct_q;
    bpm_err_d  = bpm_err_q;
    note_err_d = note_err_q;
    div_op_d   = div_op_q;
    if (cmd_i.load_in) begin
      char_d = char_byte_i;
      end_d  = end_of_string_i;
    end
    if (cmd_i.acc_clr) acc_d = 16'd0;
    if (cmd_i.acc_add) acc_d = (acc_q << 3) + (acc_q << 1) + {12'd0, digit};
    if (cmd_i.set_dlen) dlen_d = acc_q[7:0];
    if (cmd_i.set_doct) doct_d = char_q[2:0];
    if (cmd_i.set_bpm) bpm_d = acc_q[7:0];
    if (cmd_i.whole_zero) begin
      whole_d   = 16'd0;
      bpm_err_d = 1'b1;
    end
    if (cmd_i.div_start) div_op_d = cmd_i.div_note;
    if (div_done) begin
      if (div_op_q) begin
        dur_d      = quotient;
        note_err_d = 1'b0;
      end else begin
        whole_d   = {quotient[13:0], 2'b00};
        bpm_err_d = 1'b0;
      end
    end
    if (cmd_i.dur_zero) begin
      dur_d      = 16'd0;
      note_err_d = 1'b1;
    end
    if (cmd_i.set_semi) semi_d = rnp_pkg::letter_semitone(char_q);
    if (cmd_i.semi_inc) semi_d = semi_q + 4'd1;
    if (cmd_i.dur_dot) dur_d = dur_q + (dur_q >> 1);
    if (cmd_i.oct_digit) oct_d = {4'd0, digit} + octave_shift_i;
    if (cmd_i.oct_def) oct_d = {5'd0, doct_q} + octave_shift_i;
    if (cmd_i.restart) begin
      acc_d      = 16'd0;
      dlen_d     = rnp_pkg::DEF_LENGTH;
      doct_d     = rnp_pkg::DEF_OCTAVE;
      bpm_d      = rnp_pkg::DEF_BPM;
      whole_d    = 16'd0;
      semi_d     = 4'd0;
      dur_d      = 16'd0;
      oct_d      = 8'd0;
      bpm_err_d  = 1'b0;
      note_err_d = 1'b0;
    end
  end

  // output handshake
  always_comb begin
    ovld_d  = ovld_q;
    olast_d = olast_q;
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    if (cmd_i.rel_out) begin
      ovld_d  = 1'b1;
      olast_d = cmd_i.rel_last;
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 16'd0;
      dlen_q     <= rnp_pkg::DEF_LENGTH;
      doct_q     <= rnp_pkg::DEF_OCTAVE;
      bpm_q      <= rnp_pkg::DEF_BPM;
      whole_q    <= 16'd0;
      semi_q     <= 4'd0;
      dur_q      <= 16'd0;
      oct_q      <= 8'd0;
      bpm_err_q  <= 1'b0;
      note_err_q <= 1'b0;
      div_op_q   <= 1'b0;
      ovld_q     <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      dlen_q     <= dlen_d;
      doct_q     <= doct_d;
      bpm_q      <= bpm_d;
      whole_q    <= whole_d;
      semi_q     <= semi_d;
      dur_q      <= dur_d;
      oct_q      <= oct_d;
      bpm_err_q  <= bpm_err_d;
      note_err_q <= note_err_d;
      div_op_q   <= div_op_d;
      ovld_q     <= ovld_d;
      olast_q    <= olast_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    end_q  <= end_d;
    if (cmd_i.ld_out) begin
      opitch_q <= (!rest && in_rng) ? idx_s[5:0] : 6'd0;
      opval_q  <= rest || in_rng;
      orest_q  <= rest;
      odur_q   <= dur_q;
      oerr_q   <= bpm_err_q || note_err_q;
    end
  end

  assign out_valid_o   = ovld_q;
  assign pitch_index_o = opitch_q;
  assign pitch_valid_o = opval_q;
  assign is_rest_o     = orest_q;
  assign duration_ms_o = odur_q;
  assign div_error_o   = oerr_q;
  assign last_note_o   = olast_q;

endmodule

FILE: hw/rtl/rnp_ctrl.sv
// ============================================================================
// rnp_ctrl - ringtone parser controller
// Walks each byte's parse phases, one per cycle outside divider and output
// waits, starts the divider where a division is due, sequences result releases.
// ============================================================================
module rnp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rnp_pkg::rnp_stat_t stat_i,
  output rnp_pkg::rnp_cmd_t  cmd_o
);

  // parse phases
  localparam logic [3:0] PH_NAME   = 4'd0;
  localparam logic [3:0] PH_DCHK   = 4'd1;
  localparam logic [3:0] PH_DEQ    = 4'd2;
  localparam logic [3:0] PH_DNUM   = 4'd3;
  localparam logic [3:0] PH_OCHK   = 4'd4;
  localparam logic [3:0] PH_OEQ    = 4'd5;
  localparam logic [3:0] PH_OVAL   = 4'd6;
  localparam logic [3:0] PH_OCOMMA = 4'd7;
  localparam logic [3:0] PH_BCHK   = 4'd8;
  localparam logic [3:0] PH_BEQ    = 4'd9;
  localparam logic [3:0] PH_BNUM   = 4'd10;
  localparam logic [3:0] PH_NDUR   = 4'd11;
  localparam logic [3:0] PH_NSHARP = 4'd12;
  localparam logic [3:0] PH_NDOT   = 4'd13;
  localparam logic [3:0] PH_NOCT   = 4'd14;
  localparam logic [3:0] PH_NCOMMA = 4'd15;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_FORM = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_ENDW = 3'd5;

  logic [2:0] seq_q, seq_d;
  logic [3:0] phase_q, phase_d;
  logic       cons_q, cons_d;     // byte consumed once the division is done
  logic       staged_q, staged_d; // a result waits in the output register
  logic       end_emit;

  assign in_ready_o = (seq_q == S_IDLE);
  assign end_emit   = stat_i.end_flag && (phase_q >= PH_NSHARP);

  always_comb begin
    cmd_o    = '0;
    seq_d    = seq_q;
    phase_d  = phase_q;
    cons_d   = cons_q;
    staged_d = staged_q;
    unique case (seq_q)
      // wait for a request
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          seq_d         = S_STEP;
        end
      end
      // one parse phase
      S_STEP: begin
        seq_d = S_FIN;
        unique case (phase_q)
          PH_NAME: begin
            if (stat_i.is_colon) phase_d = PH_DCHK;
          end
          PH_DCHK: begin
            if (stat_i.is_d) phase_d = PH_DEQ;
            else begin
              phase_d = PH_OCHK;
              seq_d   = S_STEP;
            end
          end
          PH_DEQ: begin
            phase_d       = PH_DNUM;
            cmd_o.acc_clr = 1'b1;
          end
          PH_DNUM: begin
            if (stat_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_dlen = !stat_i.acc_zero;
              phase_d        = PH_OCHK;
            end
          end
          PH_OCHK: begin
            if (stat_i.is_o) phase_d = PH_OEQ;
            else begin
              phase_d = PH_BCHK;
              seq_d   = S_STEP;
            end
          end
          PH_OEQ: phase_d = PH_OVAL;
          PH_OVAL: begin
            cmd_o.set_doct = stat_i.oct_ok;
            phase_d        = PH_OCOMMA;
          end
          PH_OCOMMA: phase_d = PH_BCHK;
          PH_BCHK: begin
            if (stat_i.is_b) phase_d = PH_BEQ;
            else begin
              cons_d = 1'b0;
              seq_d  = S_FORM;
            end
          end
          PH_BEQ: begin
            phase_d       = PH_BNUM;
            cmd_o.acc_clr = 1'b1;
          end
          PH_BNUM: begin
            if (stat_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_bpm = 1'b1;
              cons_d        = 1'b1;
              seq_d         = S_FORM;
            end
          end
          PH_NDUR: begin
            if (stat_i.is_digit) cmd_o.acc_add = 1'b1;
            else begin
              cmd_o.set_semi = 1'b1;
              phase_d        = PH_NSHARP;
              cons_d         = 1'b1;
              if (stat_i.div_zero) cmd_o.dur_zero = 1'b1;
              else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_note  = 1'b1;
                seq_d           = S_DIV;
              end
            end
          end
          PH_NSHARP: begin
            phase_d = PH_NDOT;
            if (stat_i.is_sharp) cmd_o.semi_inc = 1'b1;
            else seq_d = S_STEP;
          end
          PH_NDOT: begin
            phase_d = PH_NOCT;
            if (stat_i.is_dot) cmd_o.dur_dot = 1'b1;
            else seq_d = S_STEP;
          end
          PH_NOCT: begin
            phase_d = PH_NCOMMA;
            if (stat_i.is_digit) cmd_o.oct_digit = 1'b1;
            else begin
              cmd_o.oct_def = 1'b1;
              seq_d         = S_STEP;
            end
          end
          PH_NCOMMA: begin
            // the finished note waits until the output register is free
            if (stat_i.out_busy) seq_d = S_STEP;
            else begin
              cmd_o.ld_out  = 1'b1;
              staged_d      = 1'b1;
              phase_d       = PH_NDUR;
              cmd_o.acc_clr = 1'b1;
              if (!stat_i.is_comma) seq_d = S_STEP;
            end
          end
          default: phase_d = PH_NAME;
        endcase
      end
      // whole note time from the tempo, then start the notes
      S_FORM: begin
        phase_d       = PH_NDUR;
        cmd_o.acc_clr = 1'b1;
        if (stat_i.bpm_zero) begin
          cmd_o.whole_zero = 1'b1;
          seq_d            = cons_q ? S_FIN : S_STEP;
        end else begin
          cmd_o.div_start = 1'b1;
          seq_d           = S_DIV;
        end
      end
      // wait for the divider
      S_DIV: begin
        if (stat_i.div_done) seq_d = cons_q ? S_FIN : S_STEP;
      end
      // byte consumed: release results, handle end of string
      S_FIN: begin
        seq_d = S_IDLE;
        if (staged_q) begin
          cmd_o.rel_out  = 1'b1;
          cmd_o.rel_last = stat_i.end_flag && !end_emit;
          staged_d       = 1'b0;
        end
        if (end_emit) seq_d = S_ENDW;
        else if (stat_i.end_flag) begin
          cmd_o.restart = 1'b1;
          phase_d       = PH_NAME;
        end
      end
      // note cut short by the end of the string
      S_ENDW: begin
        if (!stat_i.out_busy) begin
          cmd_o.ld_out      = 1'b1;
          cmd_o.use_def_oct = (phase_q != PH_NCOMMA);
          cmd_o.rel_out     = 1'b1;
          cmd_o.rel_last    = 1'b1;
          cmd_o.restart     = 1'b1;
          phase_d           = PH_NAME;
          seq_d             = S_IDLE;
        end
      end
      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= S_IDLE;
      phase_q  <= PH_NAME;
      cons_q   <= 1'b0;
      staged_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      cons_q   <= cons_d;
      staged_q <= staged_d;
    end
  end

  // a result never overwrites one still waiting at the output
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> !stat_i.out_busy)
    else $error("result loaded over a pending one");

  // a released result shows on the output next cycle
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rel_out |=> stat_i.out_busy)
    else $error("released result not presented");

  // a staged note never outlives its byte
  a_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    staged_q |-> (seq_q == S_STEP || seq_q == S_DIV || seq_q == S_FIN))
    else $error("staged result outside byte processing");

  // the divider only finishes while the controller waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (seq_q == S_DIV))
    else $error("divider finished outside the wait state");

endmodule

FILE: hw/rtl/rtttl_note_parser_unit.sv
// ============================================================================
// rtttl_note_parser_unit - ringtone string parser, top level
// Byte-wise parser of ringtone strings: header defaults, tempo and one
// result per note, with an APB-style port for the octave shift register.
// ============================================================================
// One request carries one byte of the string. It is taken when the block is
// idle and holds the block while the byte passes through its parse phases;
// forming the tempo adds a step of its own. Where a byte closes the tempo
// header or a note's duration field, the byte also waits for the shared
// divider. A note letter that directly follows the header runs the divider
// twice. A result waits in the output register while the next byte is taken;
// a byte that emits a result while one is still pending there stalls until
// it has been taken. A byte gives at most two results. No clearing pass
// follows reset.
module rtttl_note_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_string_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pitch_index_o,
  output logic        pitch_valid_o,
  output logic        is_rest_o,
  output logic [15:0] duration_ms_o,
  output logic        div_error_o,
  output logic        last_note_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rnp_pkg::rnp_cmd_t  cmd;
  rnp_pkg::rnp_stat_t stat;
  logic [7:0]         oct_shift_q;
  logic               sel_shift;

  // octave shift register
  assign pready    = 1'b1;
  assign sel_shift = (paddr[2] == rnp_pkg::REG_OCTAVE_SHIFT);
  assign prdata    = sel_shift ? {24'd0, oct_shift_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_shift_q <= 8'd0;
    end else if (psel && penable && pwrite && pready && sel_shift) begin
      oct_shift_q <= pwdata[7:0];
    end
  end

  rnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rnp_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .char_byte_i     (char_byte_i),
    .end_of_string_i (end_of_string_i),
    .octave_shift_i  (oct_shift_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .pitch_index_o   (pitch_index_o),
    .pitch_valid_o   (pitch_valid_o),
    .is_rest_o       (is_rest_o),
    .duration_ms_o   (duration_ms_o),
    .div_error_o     (div_error_o),
    .last_note_o     (last_note_o)
  );

endmodule
